[hw/rtl/vpr_pkg.sv]
// ----------------------------------------------------------------------------
// vpr_pkg
// Shared types and codes of the voice parameter ramp engine.
// ----------------------------------------------------------------------------
`default_nettype none

package vpr_pkg;

    localparam logic       OP_START   = 1'b0;
    localparam logic       OP_TICK    = 1'b1;

    localparam logic [1:0] PARAM_VOL  = 2'd0;
    localparam logic [1:0] PARAM_PAN  = 2'd1;
    localparam logic [1:0] PARAM_FREQ = 2'd2;
    localparam logic [1:0] PARAM_BAD  = 2'd3;

    localparam int         NPARAM     = 3;
    localparam logic [19:0] VOL_MAX   = 20'd255;

    typedef struct packed {
        logic        operation;
        logic [3:0]  voice;
        logic [1:0]  param;
        logic [15:0] ramp_ms;
        logic [19:0] target_value;
        logic [19:0] current_value;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  out_voice;
        logic [1:0]  out_param;
        logic [19:0] value;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic [19:0] start_v;
        logic [19:0] end_v;
        logic [15:0] length;
        logic [15:0] elapsed;
    } t_ramp;

endpackage

`default_nettype wire

[hw/rtl/vpr_if.sv]
// ----------------------------------------------------------------------------
// vpr_if
// Valid/ready channels of the ramp engine: request beats in, result beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpr_in_if import vpr_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vpr_out_if import vpr_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/voice_parameter_ramp_engine_unit.sv]
// ----------------------------------------------------------------------------
// voice_parameter_ramp_engine_unit
// Linear ramp table for voice volume, pan and frequency, bit-serial datapath.
//
//   port    dir  beat        contents
//   i_req   in   t_in_beat   start ramp or 1 ms tick
//   o_rsp   out  t_out_beat  voice, param, clamped value, last
//
// A tick scans all VOICES*3 entries in order; each active ramp goes through read,
// load, a bit-serial multiply, a restoring divide and write-back, while idle
// entries are skipped.
// Reset clears the state, the output-valid flag and the active and frequency-valid bits only.
// i_req is ready when the scan is idle and the output register is empty;
// a stalled o_rsp holds the scan at the write-back step.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_parameter_ramp_engine_unit import vpr_pkg::*; #(
    parameter int VOICES    = 16,
    parameter int FREQ_BITS = 20
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vpr_in_if.sink     i_req,
    vpr_out_if.source  o_rsp
);

    localparam int LP_NE = VOICES * NPARAM;
    localparam int LP_IW = $clog2(LP_NE);
    localparam int LP_AW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int LP_FW = (FREQ_BITS < 20) ? FREQ_BITS : 20;
    localparam logic [19:0] FREQ_MAX = 20'((64'd1 << LP_FW) - 64'd1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    function automatic logic [19:0] f_clamp(input logic [1:0] p, input logic [20:0] v);
        logic [19:0] res;
        if (p == PARAM_FREQ) begin
            if (v == 21'd0) res = 20'd1;
            else if (v > {1'b0, FREQ_MAX}) res = FREQ_MAX;
            else res = v[19:0];
        end else begin
            res = (v > {1'b0, VOL_MAX}) ? VOL_MAX : v[19:0];
        end
        return res;
    endfunction

    logic [2:0]        r_state;
    logic [LP_IW-1:0]  r_idx;
    logic [4:0]        r_wvoice;
    logic [1:0]        r_wparam;
    logic [LP_NE-1:0]  r_active;
    logic [VOICES-1:0] r_fvalid;
    logic [LP_FW-1:0]  r_afreq [VOICES];
    t_ramp             r_mem [LP_NE];
    t_ramp             r_rd;
    t_ramp             r_ent;
    logic              r_dn;
    logic [19:0]       r_d;
    logic [35:0]       r_acc;
    logic [15:0]       r_mpl;
    logic [37:0]       r_num;
    logic [17:0]       r_rem;
    logic [16:0]       r_den;
    logic [5:0]        r_cnt;
    logic              r_ov;
    t_out_beat         r_ob;

    t_in_beat          w_in;
    logic              w_acc;
    logic [4:0]        w_v5;
    logic              w_ok;
    logic [LP_IW-1:0]  w_sidx;
    logic [LP_AW-1:0]  w_aidx;
    logic [19:0]       w_endc;
    logic [19:0]       w_startv;
    logic [15:0]       n_el;
    logic [35:0]       n_acc;
    logic [37:0]       n_num;
    logic [17:0]       w_rs;
    logic              w_ge;
    logic [20:0]       w_val;
    logic [19:0]       w_outv;
    logic [LP_NE-1:0]  w_upto;
    logic              w_last;
    logic              w_done;
    logic              w_emit;
    logic              w_at_end;
    logic              w_we;
    logic [LP_IW-1:0]  w_wa;
    t_ramp             w_wd;
    logic [LP_AW-1:0]  w_waidx;

    assign w_in   = i_req.data;
    assign i_req.ready = (r_state == ST_IDLE) && !r_ov;
    assign w_acc  = i_req.valid && i_req.ready;
    assign w_v5   = {1'b0, w_in.voice};
    assign w_ok   = (w_v5 < 5'(VOICES)) && (w_in.param != PARAM_BAD);
    assign w_sidx = LP_IW'(7'({w_v5, 1'b0}) + 7'(w_v5) + 7'(w_in.param));
    assign w_aidx = w_v5[LP_AW-1:0];
    assign w_endc = f_clamp(w_in.param, {1'b0, w_in.target_value});

    always_comb begin
        if (w_in.param == PARAM_FREQ) begin
            if (r_fvalid[w_aidx]) w_startv = 20'(r_afreq[w_aidx]);
            else w_startv = (w_in.current_value > FREQ_MAX) ? FREQ_MAX : w_in.current_value;
        end else begin
            w_startv = (w_in.current_value > VOL_MAX) ? VOL_MAX : w_in.current_value;
        end
    end

    // walk datapath
    assign n_el   = (r_rd.elapsed < r_rd.length) ? r_rd.elapsed + 16'd1 : r_rd.elapsed;
    assign n_acc  = {r_acc[34:0], 1'b0} + (r_mpl[15] ? 36'(r_d) : 36'd0);
    assign n_num  = {n_acc, 1'b0} + 38'(r_ent.length) - 38'(r_dn);
    assign w_rs   = {r_rem[16:0], r_num[37]};
    assign w_ge   = w_rs >= {1'b0, r_den};
    assign w_val  = r_dn ? {1'b0, r_ent.start_v} - {1'b0, r_num[19:0]}
                         : {1'b0, r_ent.start_v} + {1'b0, r_num[19:0]};
    assign w_outv = f_clamp(r_wparam, w_val);
    assign w_upto = (LP_NE'(2) << r_idx) - LP_NE'(1);
    assign w_last = ~|(r_active & ~w_upto);
    assign w_done = r_ent.elapsed >= r_ent.length;
    assign w_emit = (r_state == ST_EMIT) && !r_ov;
    assign w_at_end = r_idx == LP_IW'(LP_NE - 1);
    assign w_waidx = r_wvoice[LP_AW-1:0];

    always_comb begin
        w_we = 1'b0;
        w_wa = r_idx;
        w_wd = r_ent;
        if (w_acc && w_in.operation == OP_START && w_ok && w_in.ramp_ms != 16'd0) begin
            w_we = 1'b1;
            w_wa = w_sidx;
            w_wd = '{start_v: w_startv, end_v: w_endc,
                     length: w_in.ramp_ms, elapsed: 16'd0};
        end else if (w_emit) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ov     <= 1'b0;
            r_active <= '0;
            r_fvalid <= '0;
        end else begin
            if (r_ov && o_rsp.ready) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (w_in.operation == OP_TICK) begin
                            r_state <= ST_SCAN;
                        end else if (w_ok && w_in.ramp_ms == 16'd0) begin
                            r_ov <= 1'b1;
                            if (w_in.param == PARAM_FREQ) r_fvalid[w_aidx] <= 1'b1;
                        end else if (w_ok) begin
                            r_active[w_sidx] <= 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_active[r_idx]) r_state <= ST_LOAD;
                    else if (w_at_end) r_state <= ST_IDLE;
                end
                ST_LOAD: r_state <= ST_MUL;
                ST_MUL:  if (r_cnt == 6'd0) r_state <= ST_DIV;
                ST_DIV:  if (r_cnt == 6'd0) r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        if (w_done) r_active[r_idx] <= 1'b0;
                        if (r_wparam == PARAM_FREQ) r_fvalid[w_waidx] <= 1'b1;
                        r_state <= w_at_end ? ST_IDLE : ST_SCAN;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_idx    <= '0;
                r_wvoice <= 5'd0;
                r_wparam <= PARAM_VOL;
                if (w_acc && w_in.operation == OP_START && w_ok && w_in.ramp_ms == 16'd0) begin
                    r_ob <= '{out_voice: w_in.voice, out_param: w_in.param,
                              value: w_endc, last: 1'b1};
                    if (w_in.param == PARAM_FREQ) r_afreq[w_aidx] <= w_endc[LP_FW-1:0];
                end
            end
            ST_SCAN: begin
                if (!r_active[r_idx] && !w_at_end) begin
                    r_idx <= r_idx + LP_IW'(1);
                    if (r_wparam == PARAM_FREQ) begin
                        r_wparam <= PARAM_VOL;
                        r_wvoice <= r_wvoice + 5'd1;
                    end else begin
                        r_wparam <= r_wparam + 2'd1;
                    end
                end
            end
            ST_LOAD: begin
                r_ent <= '{start_v: r_rd.start_v, end_v: r_rd.end_v,
                           length: r_rd.length, elapsed: n_el};
                r_dn  <= r_rd.end_v < r_rd.start_v;
                r_d   <= (r_rd.end_v < r_rd.start_v) ? r_rd.start_v - r_rd.end_v
                                                     : r_rd.end_v - r_rd.start_v;
                r_acc <= 36'd0;
                r_mpl <= n_el;
                r_cnt <= 6'd15;
            end
            ST_MUL: begin
                r_acc <= n_acc;
                r_mpl <= {r_mpl[14:0], 1'b0};
                if (r_cnt == 6'd0) begin
                    r_num <= n_num;
                    r_den <= {r_ent.length, 1'b0};
                    r_rem <= 18'd0;
                    r_cnt <= 6'd37;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
            ST_DIV: begin
                r_rem <= w_ge ? w_rs - {1'b0, r_den} : w_rs;
                r_num <= {r_num[36:0], w_ge};
                r_cnt <= r_cnt - 6'd1;
            end
            ST_EMIT: begin
                if (!r_ov) begin
                    r_ob <= '{out_voice: r_wvoice[3:0], out_param: r_wparam,
                              value: w_outv, last: w_last};
                    if (r_wparam == PARAM_FREQ) r_afreq[w_waidx] <= w_outv[LP_FW-1:0];
                    if (!w_at_end) begin
                        r_idx <= r_idx + LP_IW'(1);
                        if (r_wparam == PARAM_FREQ) begin
                            r_wparam <= PARAM_VOL;
                            r_wvoice <= r_wvoice + 5'd1;
                        end else begin
                            r_wparam <= r_wparam + 2'd1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_ob;

    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.out_param != PARAM_FREQ |-> o_rsp.data.value <= VOL_MAX)
        else $error("volume or pan result above 255");

    a_freq_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.out_param == PARAM_FREQ |-> o_rsp.data.value != 20'd0)
        else $error("frequency result of zero");

    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EMIT |-> r_num[37:20] == 18'd0 && r_num[19:0] <= r_d)
        else $error("interpolation step beyond ramp span");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_ov)
        else $error("write-back without result beat");

endmodule

`default_nettype wire
